// File: hdl/aes_pkg.sv
package aes_pkg;

    localparam int ROUND_COUNT = 14;
    localparam int SCHED_WORDS = 60;
    localparam int KEY_ROWS    = ROUND_COUNT + 1;
    localparam int ROW_W       = $clog2(KEY_ROWS);
    localparam int CNT_W       = $clog2(SCHED_WORDS);
    localparam int KEY_W       = 256;
    localparam int BLK_W       = 128;
    localparam int HALF_W      = 64;
    localparam int WORD_W      = 32;
    localparam int KEY_NWORDS  = KEY_W / WORD_W;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1B;

    typedef enum logic [1:0] {
        REG_KEY_WORD_0 = 2'd0,
        REG_KEY_WORD_1 = 2'd1,
        REG_KEY_WORD_2 = 2'd2,
        REG_KEY_WORD_3 = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic             start;
        logic [ROW_W-1:0] rd_row;
    } t_ks_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ks_stat;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    function automatic logic [WORD_W-1:0] word_subst(input logic [WORD_W-1:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

// File: hdl/aes_in_if.sv
interface aes_in_if import aes_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] plain_high;
    logic [HALF_W-1:0] plain_low;

    modport source (output valid, output plain_high, output plain_low, input ready);
    modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

// File: hdl/aes_out_if.sv
interface aes_out_if import aes_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] cipher_high;
    logic [HALF_W-1:0] cipher_low;

    modport source (output valid, output cipher_high, output cipher_low, input ready);
    modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

// File: hdl/aes_cfg_if.sv
interface aes_cfg_if import aes_pkg::*; ();
    logic              valid;
    logic              ready;
    t_cfg_reg          index;
    logic [HALF_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/aes_round.sv
module aes_round import aes_pkg::*; (
    input  logic [BLK_W-1:0] i_state,
    input  logic [BLK_W-1:0] i_rk,
    input  logic             i_last,
    output logic [BLK_W-1:0] o_state
);

    logic [7:0] st [16];
    logic [7:0] sh [16];
    logic [7:0] mx [16];
    logic [7:0] x;

    always_comb begin
        x = 8'h00;
        for (int k = 0; k < 16; k++) begin
            st[k] = i_state[BLK_W-1-8*k -: 8];
        end
        // SubBytes with ShiftRows: row i of column c takes column c+i
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sh[c*4+i] = sbox(st[((c+i)%4)*4+i]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            x = sh[c*4] ^ sh[c*4+1] ^ sh[c*4+2] ^ sh[c*4+3];
            for (int i = 0; i < 4; i++) begin
                mx[c*4+i] = i_last ? sh[c*4+i]
                          : sh[c*4+i] ^ x ^ xtime(sh[c*4+i] ^ sh[c*4+((i+1)%4)]);
            end
        end
        for (int k = 0; k < 16; k++) begin
            o_state[BLK_W-1-8*k -: 8] = mx[k] ^ i_rk[BLK_W-1-8*k -: 8];
        end
    end

endmodule

// File: hdl/aes_key_sched.sv
module aes_key_sched import aes_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ks_req          i_req,
    input  logic [KEY_W-1:0] i_key,
    output t_ks_stat         o_stat,
    output logic [BLK_W-1:0] o_rk
);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [7:0]        r_rcon;
    logic [WORD_W-1:0] r_win [KEY_NWORDS];
    logic [BLK_W-1:0]  r_mem [KEY_ROWS];
    logic [BLK_W-1:0]  r_rk;

    logic [2:0]        w_kidx;
    logic [WORD_W-1:0] w_t;
    logic [WORD_W-1:0] n_word;
    logic              w_last;

    assign w_kidx = 3'd7 - r_cnt[2:0];
    assign w_last = (r_cnt == CNT_W'(SCHED_WORDS - 1));

    always_comb begin
        w_t = r_win[KEY_NWORDS-1];
        if (r_cnt[2:0] == 3'd0) begin
            w_t = word_subst({w_t[23:0], w_t[31:24]}) ^ {r_rcon, 24'h000000};
        end else if (r_cnt[2:0] == 3'd4) begin
            w_t = word_subst(w_t);
        end
        if (r_cnt < CNT_W'(KEY_NWORDS)) begin
            n_word = i_key[w_kidx*WORD_W +: WORD_W];
        end else begin
            n_word = r_win[0] ^ w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_rcon <= RCON_INIT;
        end else if (!r_busy) begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rcon <= RCON_INIT;
            end
        end else begin
            if (r_cnt >= CNT_W'(KEY_NWORDS) && r_cnt[2:0] == 3'd0) begin
                r_rcon <= xtime(r_rcon);
            end
            if (w_last) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // sliding window of the last eight schedule words
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            for (int k = 0; k < KEY_NWORDS - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[KEY_NWORDS-1] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_cnt[CNT_W-1:2]][(2'd3 - r_cnt[1:0])*WORD_W +: WORD_W] <= n_word;
        end
        r_rk <= r_mem[i_req.rd_row];
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && w_last;
    assign o_rk        = r_rk;

endmodule

// File: hdl/aes256_block_encryptor.sv
// Sequence: initial key addition when a block is accepted, then 14 rounds, one per
//   cycle; the final round waits until the output register is free or being drained.
// A new block is accepted only after the previous one finishes its final round.
// Key expansion: 60 schedule words, one per cycle, before the first block after
//   reset or after any key write; no block is taken meanwhile.
// Reset: synchronous active low; key registers clear to zero, schedule marked stale.
module aes256_block_encryptor import aes_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aes_cfg_if.sink   i_cfg,
    aes_in_if.sink    i_blk,
    aes_out_if.source o_blk
);

    // Key registers, written through the configuration channel
    logic [HALF_W-1:0] r_key [4];
    logic              r_stale;

    // Sequencer
    t_state            r_fsm,   n_fsm;
    logic [ROW_W-1:0]  r_round, n_round;

    // Datapath
    logic [BLK_W-1:0]  r_blk;
    logic [BLK_W-1:0]  r_out;
    logic              r_out_valid;

    t_ks_req           ks_req;
    t_ks_stat          ks_stat;
    logic [BLK_W-1:0]  rk;
    logic [BLK_W-1:0]  round_out;
    logic              in_acc;
    logic              cfg_acc;
    logic              last_round;
    logic              finish;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    // Accept a block only when idle and the schedule is fresh
    assign i_blk.ready = (r_fsm == ST_IDLE) && !r_stale;
    assign in_acc      = i_blk.valid && i_blk.ready;

    assign last_round = (r_round == ROW_W'(ROUND_COUNT));
    // The final round lands in the output register once it is free or being drained
    assign finish     = (r_fsm == ST_ROUND) && last_round && (!r_out_valid || o_blk.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                REG_KEY_WORD_0: r_key[0] <= i_cfg.data;
                REG_KEY_WORD_1: r_key[1] <= i_cfg.data;
                REG_KEY_WORD_2: r_key[2] <= i_cfg.data;
                REG_KEY_WORD_3: r_key[3] <= i_cfg.data;
            endcase
        end
    end

    // Any key write stales the schedule; launching the expansion refreshes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale <= 1'b1;
        end else if (cfg_acc) begin
            r_stale <= 1'b1;
        end else if (ks_req.start) begin
            r_stale <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= ST_IDLE;
            r_round <= '0;
        end else begin
            r_fsm   <= n_fsm;
            r_round <= n_round;
        end
    end

    always_comb begin
        n_fsm        = r_fsm;
        n_round      = r_round;
        ks_req.start = 1'b0;
        unique case (r_fsm)
            ST_IDLE: begin
                if (r_stale) begin
                    ks_req.start = 1'b1;
                    n_fsm        = ST_EXPAND;
                end else if (i_blk.valid) begin
                    n_round = ROW_W'(1);
                    n_fsm   = ST_ROUND;
                end
            end
            ST_EXPAND: begin
                if (ks_stat.done) begin
                    n_fsm = ST_IDLE;
                end
            end
            ST_ROUND: begin
                if (!last_round) begin
                    n_round = r_round + 1'b1;
                end else if (finish) begin
                    n_round = '0;
                    n_fsm   = ST_IDLE;
                end
            end
            default: begin
                n_fsm   = ST_IDLE;
                n_round = '0;
            end
        endcase
        // Fetch the key for the round about to run; hold it across an output stall
        ks_req.rd_row = n_round;
    end

    aes_key_sched u_key_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ks_req),
        .i_key   ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .o_stat  (ks_stat),
        .o_rk    (rk)
    );

    aes_round u_round (
        .i_state (r_blk),
        .i_rk    (rk),
        .i_last  (last_round),
        .o_state (round_out)
    );

    // State register: initial key addition on accept, then one round per cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_blk <= {i_blk.plain_high, i_blk.plain_low} ^ rk;
        end else if (r_fsm == ST_ROUND && !last_round) begin
            r_blk <= round_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_blk.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= round_out;
        end
    end

    assign o_blk.valid       = r_out_valid;
    assign o_blk.cipher_high = r_out[BLK_W-1:HALF_W];
    assign o_blk.cipher_low  = r_out[HALF_W-1:0];

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == ST_ROUND |-> r_round != '0 && r_round <= ROW_W'(ROUND_COUNT))
        else $error("round counter out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_fsm == ST_ROUND && r_round == ROW_W'(1))
        else $error("accepted block did not start round one");

    a_no_expand_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == ST_ROUND |-> !ks_stat.busy)
        else $error("key expansion running during encryption");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_blk.ready |=> r_out_valid && $stable(r_out))
        else $error("pending ciphertext overwritten");

endmodule
